### rtl/keyboard_report_line_editor_macros.svh
// assertion macros for the keyboard report line editor checker
// no dependencies; included by files that hold concurrent assertions
`ifndef KEYBOARD_REPORT_LINE_EDITOR_MACROS_SVH
`define KEYBOARD_REPORT_LINE_EDITOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define KRLE_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define KRLE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/krle_pkg.sv
// shared types, keycodes and keymaps for the keyboard report line editor
// no dependencies; imported by every rtl module
package krle_pkg;

	localparam int MAX_CHARS   = 63;
	localparam int POS_W       = 6;
	localparam int CHAR_W      = 7;
	localparam int KEY_W       = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - CHAR_W - 2 * POS_W;
	localparam int KIND_W      = 3;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int MAP_DEPTH   = 28;
	localparam int MAP_IDX_W   = $clog2(MAP_DEPTH);

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [KEY_W-1:0]  key_t;

	localparam key_t KEY_FIRST       = 8'h04;
	localparam key_t KEY_LETTER_LAST = 8'h1d;
	localparam key_t KEY_DIGIT_FIRST = 8'h1e;
	localparam key_t KEY_MAP_LAST    = 8'h39;
	localparam key_t KEY_ENTER       = 8'h28;
	localparam key_t KEY_ESC         = 8'h29;
	localparam key_t KEY_BKSP        = 8'h2a;
	localparam key_t KEY_TAB         = 8'h2b;
	localparam key_t KEY_RIGHT       = 8'h4f;
	localparam key_t KEY_LEFT        = 8'h50;
	localparam key_t KEY_ARROW_LAST  = 8'h52;
	localparam key_t SHIFT_MASK      = 8'h22;
	localparam key_t SHIFT_OFFSET    = 8'd61;
	localparam key_t PLAIN_OFFSET    = 8'd93;
	localparam char_t ASCII_SPACE    = 7'h20;

	typedef enum logic [KIND_W-1:0] {
		EV_IGNORED,
		EV_INSERTED,
		EV_DELETED,
		EV_MOVED,
		EV_LINE_CHAR,
		EV_LINE_END,
		EV_ESCAPE
	} event_kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAB,
		OP_RIGHT,
		OP_LEFT,
		OP_ARROW_NOP,
		OP_BKSP,
		OP_ENTER,
		OP_ESC,
		OP_KEY
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		op_t   op;
		key_t  key_a;
		key_t  key_b;
		char_t ch_a;
		char_t ch_b;
	} cmd_t;

	typedef struct packed {
		event_kind_t kind;
		char_t       ch;
		pos_t        cursor;
		pos_t        length;
		logic        last;
	} result_t;

	localparam char_t PLAIN_MAP [MAP_DEPTH] = '{
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h2d, 7'h3d, 7'h5b, 7'h5d, 7'h5c,
		7'h00, 7'h3b, 7'h27, 7'h60, 7'h2c, 7'h2e, 7'h2f, 7'h00
	};

	localparam char_t SHIFT_MAP [MAP_DEPTH] = '{
		7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h5f, 7'h2b, 7'h7b, 7'h7d, 7'h7c,
		7'h00, 7'h3a, 7'h22, 7'h7e, 7'h3c, 7'h3e, 7'h3f, 7'h00
	};

	// zero means the keycode has no character
	function automatic char_t map_key(key_t mods, key_t key);
		logic                 shift;
		logic [MAP_IDX_W-1:0] idx;
		key_t                 sum;
		char_t                ch;
		shift = (mods & SHIFT_MASK) != '0;
		idx   = MAP_IDX_W'(key - KEY_DIGIT_FIRST);
		sum   = key + (shift ? SHIFT_OFFSET : PLAIN_OFFSET);
		ch    = '0;
		if (key >= KEY_FIRST && key <= KEY_LETTER_LAST) begin
			ch = sum[CHAR_W-1:0];
		end else if (key >= KEY_DIGIT_FIRST && key <= KEY_MAP_LAST) begin
			ch = shift ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
		end
		return ch;
	endfunction

endpackage

### rtl/krle_front.sv
// front end: takes keyboard reports and classifies them into editor commands
// depends on krle_pkg
module krle_front (
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [krle_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic                            cmd_valid,
	input  logic                            cmd_ready,
	output krle_pkg::cmd_t                  cmd
);
	import krle_pkg::*;

	key_t mods;
	key_t k0;
	key_t k1;

	assign mods = s_axis_tdata[KEY_W-1:0];
	assign k0   = s_axis_tdata[2*KEY_W-1:KEY_W];
	assign k1   = s_axis_tdata[3*KEY_W-1:2*KEY_W];

	assign cmd_valid     = s_axis_tvalid;
	assign s_axis_tready = cmd_ready;

	always_comb begin
		cmd.key_a = k0;
		cmd.key_b = k1;
		cmd.ch_a  = map_key(mods, k0);
		cmd.ch_b  = map_key(mods, k1);
		priority if (k0 < KEY_FIRST) begin
			cmd.op = OP_NONE;
		end else if (k0 == KEY_TAB) begin
			cmd.op = OP_TAB;
		end else if (k0 == KEY_RIGHT) begin
			cmd.op = OP_RIGHT;
		end else if (k0 == KEY_LEFT) begin
			cmd.op = OP_LEFT;
		end else if (k0 > KEY_LEFT && k0 <= KEY_ARROW_LAST) begin
			cmd.op = OP_ARROW_NOP;
		end else if (k0 == KEY_BKSP) begin
			cmd.op = OP_BKSP;
		end else if (k0 == KEY_ENTER) begin
			cmd.op = OP_ENTER;
		end else if (k0 == KEY_ESC) begin
			cmd.op = OP_ESC;
		end else begin
			cmd.op = OP_KEY;
		end
	end

endmodule

### rtl/krle_cmd_queue.sv
// short command queue between the front end and the line engine
// depends on krle_pkg
module krle_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  krle_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output krle_pkg::cmd_t pop_cmd
);
	import krle_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/krle_back.sv
// line engine: line memory, cursor and length, shifting and line output
// depends on krle_pkg
module krle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  krle_pkg::cmd_t    cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output krle_pkg::result_t res
);
	import krle_pkg::*;

	back_state_t state_q, state_d;
	pos_t        len_q, len_d;
	pos_t        cur_q, cur_d;
	key_t        prev_q, prev_d;
	pos_t        idx_q, idx_d;
	logic        up_q, up_d;
	logic        tab_q, tab_d;
	char_t       ch_q, ch_d;
	pos_t        n_q, n_d;
	pos_t        rd_idx_q, rd_idx_d;
	pos_t        em_q, em_d;
	logic        rdv_q, rdv_d;
	logic        pend_q, pend_d;
	pos_t        pend_addr_q, pend_addr_d;
	char_t       rd_data_q;
	char_t       line_mem [MAX_CHARS];
	logic        out_valid_q;
	result_t     out_q;

	logic        out_free;
	logic        pop;
	logic        sel_second;
	key_t        sel_key;
	char_t       sel_ch;
	logic        key_go;
	logic        tab_go;
	logic        del_go;
	logic        enter_go;
	logic        shift_go;
	logic        more;
	logic        fire;
	logic        rd_go;
	logic        last_char;
	logic        emit;
	result_t     res_d;
	logic        mem_rd_en;
	pos_t        mem_rd_addr;
	logic        mem_wr_en;
	pos_t        mem_wr_addr;
	char_t       mem_wr_data;

	assign out_free   = !out_valid_q || res_ready;
	assign pop        = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign cmd_ready  = pop;
	assign sel_second = (cmd.key_b != '0) && (cmd.key_a == prev_q);
	assign sel_key    = sel_second ? cmd.key_b : cmd.key_a;
	assign sel_ch     = sel_second ? cmd.ch_b : cmd.ch_a;
	assign key_go     = (cmd.op == OP_KEY) && (len_q < POS_W'(MAX_CHARS))
		&& !((cmd.key_b == '0) && (cmd.key_a == prev_q)) && (sel_ch != '0);
	assign tab_go     = (cmd.op == OP_TAB)
		&& (({1'b0, len_q} + (POS_W+1)'(2)) <= (POS_W+1)'(MAX_CHARS));
	assign del_go     = (cmd.op == OP_BKSP) && (cur_q != '0);
	assign enter_go   = (cmd.op == OP_ENTER) && (len_q != '0);
	assign shift_go   = key_go || tab_go || del_go;
	assign more       = up_q ? (idx_q > cur_q)
		: (({1'b0, idx_q} + (POS_W+1)'(1)) < {1'b0, len_q});
	assign fire       = rdv_q && out_free;
	assign rd_go      = (rd_idx_q < n_q) && (!rdv_q || fire);
	assign last_char  = ({1'b0, em_q} + (POS_W+1)'(1)) == {1'b0, n_q};

	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && shift_go) begin
					state_d = ST_SHIFT;
				end else if (pop && enter_go) begin
					state_d = ST_EMIT;
				end
			end
			ST_SHIFT: begin
				if (!more && !pend_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = (up_q && tab_q) ? ST_SHIFT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (fire && last_char) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		len_d       = len_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		idx_d       = idx_q;
		up_d        = up_q;
		tab_d       = tab_q;
		ch_d        = ch_q;
		n_d         = n_q;
		rd_idx_d    = rd_idx_q;
		em_d        = em_q;
		rdv_d       = rdv_q;
		pend_d      = pend_q;
		pend_addr_d = pend_addr_q;
		emit        = 1'b0;
		res_d.kind  = EV_IGNORED;
		res_d.ch    = '0;
		res_d.last  = 1'b1;
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_idx_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = pend_addr_q;
		mem_wr_data = rd_data_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					emit = !shift_go && !enter_go;
					unique case (cmd.op)
						OP_NONE: begin
							prev_d = '0;
						end
						OP_TAB: begin
							ch_d  = ASCII_SPACE;
							tab_d = 1'b1;
							up_d  = 1'b1;
							idx_d = len_q;
						end
						OP_RIGHT: begin
							if (cur_q < len_q) begin
								cur_d      = cur_q + pos_t'(1);
								res_d.kind = EV_MOVED;
							end
						end
						OP_LEFT: begin
							if (cur_q != '0) begin
								cur_d      = cur_q - pos_t'(1);
								res_d.kind = EV_MOVED;
							end
						end
						OP_ARROW_NOP: begin
							res_d.kind = EV_IGNORED;
						end
						OP_BKSP: begin
							up_d  = 1'b0;
							idx_d = cur_q - pos_t'(1);
						end
						OP_ENTER: begin
							len_d      = '0;
							cur_d      = '0;
							prev_d     = '0;
							n_d        = len_q;
							rd_idx_d   = '0;
							em_d       = '0;
							rdv_d      = 1'b0;
							res_d.kind = EV_LINE_END;
						end
						OP_ESC: begin
							len_d      = '0;
							cur_d      = '0;
							prev_d     = '0;
							res_d.kind = EV_ESCAPE;
						end
						OP_KEY: begin
							if (key_go) begin
								ch_d   = sel_ch;
								prev_d = sel_key;
								up_d   = 1'b1;
								tab_d  = 1'b0;
								idx_d  = len_q;
							end
						end
						default: begin
							res_d.kind = EV_IGNORED;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				// read one entry while writing the one read in the previous cycle
				mem_wr_en   = pend_q;
				mem_rd_en   = more;
				mem_rd_addr = up_q ? idx_q - pos_t'(1) : idx_q + pos_t'(1);
				pend_d      = more;
				if (more) begin
					pend_addr_d = idx_q;
					idx_d       = up_q ? idx_q - pos_t'(1) : idx_q + pos_t'(1);
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					emit = 1'b1;
					if (up_q) begin
						mem_wr_en   = 1'b1;
						mem_wr_addr = cur_q;
						mem_wr_data = ch_q;
						len_d       = len_q + pos_t'(1);
						cur_d       = cur_q + pos_t'(1);
						idx_d       = len_q + pos_t'(1);
						tab_d       = 1'b0;
						res_d.kind  = EV_INSERTED;
						res_d.ch    = ch_q;
						res_d.last  = !tab_q;
					end else begin
						len_d      = len_q - pos_t'(1);
						cur_d      = cur_q - pos_t'(1);
						res_d.kind = EV_DELETED;
					end
				end
			end
			ST_EMIT: begin
				mem_rd_en = rd_go;
				if (rd_go) begin
					rd_idx_d = rd_idx_q + pos_t'(1);
				end
				rdv_d = rd_go ? 1'b1 : (fire ? 1'b0 : rdv_q);
				if (fire) begin
					emit       = 1'b1;
					em_d       = em_q + pos_t'(1);
					res_d.kind = EV_LINE_CHAR;
					res_d.ch   = rd_data_q;
					res_d.last = last_char;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		res_d.cursor = cur_d;
		res_d.length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			idx_q       <= '0;
			up_q        <= 1'b0;
			tab_q       <= 1'b0;
			n_q         <= '0;
			rd_idx_q    <= '0;
			em_q        <= '0;
			rdv_q       <= 1'b0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			cur_q       <= cur_d;
			prev_q      <= prev_d;
			idx_q       <= idx_d;
			up_q        <= up_d;
			tab_q       <= tab_d;
			n_q         <= n_d;
			rd_idx_q    <= rd_idx_d;
			em_q        <= em_d;
			rdv_q       <= rdv_d;
			pend_q      <= pend_d;
			pend_addr_q <= pend_addr_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ch_q <= ch_d;
		if (emit) begin
			out_q <= res_d;
		end
	end

	// line memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			line_mem[mem_wr_addr] <= mem_wr_data;
		end
		if (mem_rd_en) begin
			rd_data_q <= line_mem[mem_rd_addr];
		end
	end

endmodule

### rtl/keyboard_report_line_editor.sv
// top level of the keyboard report line editor
// depends on krle_pkg, krle_front, krle_cmd_queue and krle_back
//
// Boot-keyboard reports (modifier byte, two keycodes) come in on s_axis and
// each one gives one or more events on m_axis, the last marked by tlast.
// Reports are classified on entry and wait in a two-deep command queue, so
// the input can take up to two reports while the line engine works. The
// line is held in a 63-entry memory with one write and one registered read
// per cycle; its contents are undefined after reset and only the first
// length entries are ever read, so no clearing pass is run. Cursor moves,
// ignored keys and escape are answered without a shift. An insert or a
// delete shifts the tail of the line one entry per cycle; TAB runs two
// inserts. ENTER streams the line through the registered read at one
// character per cycle while m_axis is not stalled.
module keyboard_report_line_editor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// modifier_bits, first_key, second_key
	input  logic [krle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// char_code, cursor_pos, line_length, zero pad
	output logic [krle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// event_kind
	output logic [krle_pkg::KIND_W-1:0]      m_axis_tuser,
	output logic                             m_axis_tlast
);
	import krle_pkg::*;

	logic    front_valid;
	logic    front_ready;
	cmd_t    front_cmd;
	logic    q_valid;
	logic    q_ready;
	cmd_t    q_cmd;
	result_t res;

	krle_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cmd_valid     (front_valid),
		.cmd_ready     (front_ready),
		.cmd           (front_cmd)
	);

	krle_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	krle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {OUT_PAD_W'(0), res.length, res.cursor, res.ch};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

### rtl/krle_checker.sv
// port-level checks for the keyboard report line editor, bound to the top
// depends on krle_pkg and keyboard_report_line_editor_macros.svh
`include "keyboard_report_line_editor_macros.svh"

module krle_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [krle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [krle_pkg::KIND_W-1:0]      m_axis_tuser,
	input logic                             m_axis_tlast
);
	import krle_pkg::*;

	logic [CHAR_W-1:0] ch;
	logic [POS_W-1:0]  cursor;
	logic [POS_W-1:0]  length;
	logic              line_cleared;
	logic              no_char;

	assign ch           = m_axis_tdata[CHAR_W-1:0];
	assign cursor       = m_axis_tdata[CHAR_W+POS_W-1:CHAR_W];
	assign length       = m_axis_tdata[CHAR_W+2*POS_W-1:CHAR_W+POS_W];
	assign line_cleared = (m_axis_tuser == EV_LINE_CHAR) || (m_axis_tuser == EV_LINE_END)
		|| (m_axis_tuser == EV_ESCAPE);
	assign no_char      = (m_axis_tuser == EV_IGNORED) || (m_axis_tuser == EV_DELETED)
		|| (m_axis_tuser == EV_MOVED) || line_cleared && (m_axis_tuser != EV_LINE_CHAR);

	`KRLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled request changed")
	`KRLE_ASSERT_NOW(a_cursor_in_line, m_axis_tvalid, cursor <= length, "cursor beyond line end")
	`KRLE_ASSERT_NOW(a_cleared_line, m_axis_tvalid && line_cleared,
		(cursor == '0) && (length == '0), "line not cleared on enter or escape")
	`KRLE_ASSERT_NOW(a_no_char, m_axis_tvalid && no_char, ch == '0, "char on event without one")
	`KRLE_ASSERT_NOW(a_single_last, m_axis_tvalid && no_char,
		m_axis_tlast, "single-result event not marked last")

endmodule

bind keyboard_report_line_editor krle_checker u_krle_checker (.*);
